/* src/pnrh_pkg.sv */
`timescale 1ns / 1ps

package pnrh_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_INTERVAL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_LEVEL    = 1'b1;

  localparam logic [15:0] HOLD_INTERVAL_RST = 16'd25100;
  localparam logic [15:0] HOLD_LEVEL_RST    = 16'd16384;

  typedef struct packed {
    logic [15:0] hold_interval;
    logic [15:0] hold_level;
  } cfg_regs_t;

  // filter state: 40 bit signed, 24 fraction bits
  localparam int STATE_W    = 40;
  localparam int STATE_FRAC = 24;

  // coefficients, unsigned, 22 fraction bits (white gain: 24 fraction bits)
  localparam int COEF_W    = 23;
  localparam int COEF_FRAC = 22;

  localparam logic [COEF_W-1:0] POLE_SLOW  = 23'd4184447;
  localparam logic [COEF_W-1:0] GAIN_SLOW  = 23'd415429;
  localparam logic [COEF_W-1:0] POLE_MID   = 23'd4039115;
  localparam logic [COEF_W-1:0] GAIN_MID   = 23'd1243680;
  localparam logic [COEF_W-1:0] POLE_FAST  = 23'd2390753;
  localparam logic [COEF_W-1:0] GAIN_FAST  = 23'd4415307;
  localparam logic [COEF_W-1:0] GAIN_WHITE = 23'd3100430;

  // rounded white term fits well inside 25 bits
  localparam int WTERM_W = 25;

endpackage

/* src/pnrh_front.sv */
`timescale 1ns / 1ps

// Tick counter and sample-and-hold. Runs once per accepted input word.
module pnrh_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pnrh_pkg::cfg_regs_t            cfg,
  input  logic                           acc_en,
  input  logic signed [SAMPLE_WIDTH-1:0] hold_random,
  output logic signed [SAMPLE_WIDTH-1:0] held_nxt_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + 17;

  localparam logic [PW-1:0] OFFS = PW'(1) << (SW + 14);
  localparam logic [PW-1:0] HALF = PW'(1) << 14;
  localparam logic signed [SW+1:0] HMAX = (SW+2)'((1 << (SW - 1)) - 1);
  localparam logic signed [SW+1:0] HMIN = -(SW+2)'(1 << (SW - 1));

  logic [15:0]                  tick_r, tick_nxt, tick_inc;
  logic signed [SW-1:0]         held_r, held_nxt;
  logic                         reload;
  logic [SW-1:0]                h_off;
  logic [SW+15:0]               prod;
  logic signed [PW-1:0]         biased;
  logic signed [SW+1:0]         q;
  logic signed [SW-1:0]         sampled;

  // h + 1.0 is h with the sign bit flipped, taken as unsigned
  assign h_off  = {~hold_random[SW-1], hold_random[SW-2:0]};
  assign prod   = cfg.hold_level * h_off;
  assign biased = $signed({1'b0, prod} - OFFS + HALF);
  assign q      = biased[PW-1:15];

  always_comb begin
    if (q > HMAX) begin
      sampled = HMAX[SW-1:0];
    end else if (q < HMIN) begin
      sampled = HMIN[SW-1:0];
    end else begin
      sampled = q[SW-1:0];
    end
  end

  assign tick_inc = tick_r + 16'd1;
  assign reload   = tick_inc > cfg.hold_interval;

  always_comb begin
    tick_nxt = tick_r;
    held_nxt = held_r;
    if (acc_en) begin
      tick_nxt = reload ? '0 : tick_inc;
      held_nxt = reload ? sampled : held_r;
    end
  end

  // the word carries the held value after this tick's reload
  assign held_nxt_o = held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      held_r <= '0;
    end else begin
      tick_r <= tick_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* src/pnrh_queue.sv */
`timescale 1ns / 1ps

// Small FIFO between front and back.
module pnrh_queue #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output logic [DATA_W-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [AW:0]       count_r;
  logic              do_push, do_pop;

  assign full     = count_r == (AW+1)'(DEPTH);
  assign nonempty = count_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (AW+1)'(1);
        2'b01:   count_r <= count_r - (AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/pnrh_back.sv */
`timescale 1ns / 1ps

// Filter sections (stage 1) and pink sum with output register (stage 2).
module pnrh_back #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]   q_white,
  input  logic signed [SAMPLE_WIDTH-1:0]   q_held,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   white_out,
  output logic signed [SAMPLE_WIDTH+5:0]   pink_out,
  output logic signed [SAMPLE_WIDTH-1:0]   random_out
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int STW = pnrh_pkg::STATE_W;
  localparam int CW  = pnrh_pkg::COEF_W;
  localparam int WTW = pnrh_pkg::WTERM_W;
  // input gain is aligned from SW-1 to 24 fraction bits
  localparam int WSH = pnrh_pkg::STATE_FRAC - (SW - 1);
  localparam int RS  = pnrh_pkg::STATE_FRAC - (SW - 1);
  localparam int SUMW = STW + 4;

  function automatic logic signed [STW-1:0] section(
    input logic signed [STW-1:0] s,
    input logic [CW-1:0]         pole,
    input logic [CW-1:0]         gain,
    input logic signed [SW-1:0]  w
  );
    logic signed [63:0] sx, px, wx, gx, acc;
    logic signed [63-pnrh_pkg::COEF_FRAC:0] q;
    logic signed [STW-1:0] res;
    sx  = 64'(s);
    px  = $signed(64'(pole));
    wx  = 64'(w);
    gx  = $signed(64'(gain));
    acc = sx * px + ((wx * gx) <<< WSH) + (64'sd1 <<< (pnrh_pkg::COEF_FRAC - 1));
    q   = acc[63:pnrh_pkg::COEF_FRAC];
    if (q[63-pnrh_pkg::COEF_FRAC:STW-1] == '0 || q[63-pnrh_pkg::COEF_FRAC:STW-1] == '1) begin
      res = q[STW-1:0];
    end else if (q[63-pnrh_pkg::COEF_FRAC]) begin
      res = {1'b1, {(STW-1){1'b0}}};
    end else begin
      res = {1'b0, {(STW-1){1'b1}}};
    end
    return res;
  endfunction

  // stage 1: filter state and side data
  logic                   s1_valid_r;
  logic signed [STW-1:0]  slow_r, mid_r, fast_r;
  logic signed [SW-1:0]   s1_white_r, s1_held_r;
  logic signed [WTW-1:0]  s1_wterm_r;
  logic signed [SW+23:0]  wprod;
  logic                   s1_ready, s2_load;

  // stage 2: output register
  logic                   out_valid_r;
  logic signed [SW-1:0]   white_o_r, rnd_o_r;
  logic signed [SW+5:0]   pink_o_r;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-RS-1:0] pk;
  logic signed [SW+5:0]   pink_sat;

  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_ready = !s1_valid_r || s2_load;
  assign q_pop    = q_valid && s1_ready;

  assign wprod = q_white * $signed({1'b0, pnrh_pkg::GAIN_WHITE})
               + ((SW+24)'(1) <<< (SW - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      slow_r     <= '0;
      mid_r      <= '0;
      fast_r     <= '0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
        slow_r <= section(slow_r, pnrh_pkg::POLE_SLOW, pnrh_pkg::GAIN_SLOW, q_white);
        mid_r  <= section(mid_r, pnrh_pkg::POLE_MID, pnrh_pkg::GAIN_MID, q_white);
        fast_r <= section(fast_r, pnrh_pkg::POLE_FAST, pnrh_pkg::GAIN_FAST, q_white);
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_white_r <= q_white;
      s1_held_r  <= q_held;
      s1_wterm_r <= wprod[SW+WTW-2:SW-1];
    end
  end

  // pink = round(sum of sections + white term) back to SW-1 fraction bits
  assign sum = SUMW'(slow_r) + SUMW'(mid_r) + SUMW'(fast_r) + SUMW'(s1_wterm_r)
             + (SUMW'(1) <<< (RS - 1));
  assign pk  = sum[SUMW-1:RS];

  always_comb begin
    if (pk[SUMW-RS-1:SW+5] == '0 || pk[SUMW-RS-1:SW+5] == '1) begin
      pink_sat = pk[SW+5:0];
    end else if (pk[SUMW-RS-1]) begin
      pink_sat = {1'b1, {(SW+5){1'b0}}};
    end else begin
      pink_sat = {1'b0, {(SW+5){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      white_o_r <= s1_white_r;
      rnd_o_r   <= s1_held_r;
      pink_o_r  <= pink_sat;
    end
  end

  assign out_valid  = out_valid_r;
  assign white_out  = white_o_r;
  assign pink_out   = pink_o_r;
  assign random_out = rnd_o_r;

endmodule

/* src/pink_noise_and_random_hold_core.sv */
`timescale 1ns / 1ps

// Path: accepted word into the queue, then filter state (stage 1), then output register (stage 2).
// Throughput: one word per cycle while the output is not stalled; the three filter
// sections each close one constant multiply-add loop per cycle.
// Reset (rst_n low, synchronous): filter state, tick counter and held value to zero,
// hold_interval to 25100, hold_level to 16384, queue and output stages empty.
module pink_noise_and_random_hold_core #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * SAMPLE_WIDTH + 6 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // white_in, hold_random
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,  // white_out, pink_out, random_out
  // configuration writes
  input  logic                            cfg_we,
  input  logic [pnrh_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pnrh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = SAMPLE_WIDTH;

  pnrh_pkg::cfg_regs_t  cfg_r;
  logic                 q_full, q_nonempty, q_pop, acc_en;
  logic signed [SW-1:0] white_in, hold_random, held_nxt;
  logic [2*SW-1:0]      q_wdata, q_rdata;
  logic signed [SW-1:0] white_out, random_out;
  logic signed [SW+5:0] pink_out;

  // config registers: the user must write them only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_interval <= pnrh_pkg::HOLD_INTERVAL_RST;
      cfg_r.hold_level    <= pnrh_pkg::HOLD_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pnrh_pkg::CFG_HOLD_INTERVAL: cfg_r.hold_interval <= cfg_wdata;
        pnrh_pkg::CFG_HOLD_LEVEL:    cfg_r.hold_level    <= cfg_wdata;
        default:                     cfg_r <= cfg_r;
      endcase
    end
  end

  assign white_in    = in_tdata[SW-1:0];
  assign hold_random = in_tdata[2*SW-1:SW];
  assign in_tready   = !q_full;
  assign acc_en      = in_tvalid && !q_full;

  // front: tick count and held-value reload, resolved at acceptance
  pnrh_front #(.SAMPLE_WIDTH(SW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .acc_en      (acc_en),
    .hold_random (hold_random),
    .held_nxt_o  (held_nxt)
  );

  assign q_wdata = {held_nxt, white_in};

  // queue decouples acceptance from the filter pipeline
  pnrh_queue #(.DATA_W(2 * SW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc_en),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_rdata)
  );

  // back: filter sections, pink sum, output register
  pnrh_back #(.SAMPLE_WIDTH(SW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_nonempty),
    .q_white    (q_rdata[SW-1:0]),
    .q_held     (q_rdata[2*SW-1:SW]),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .white_out  (white_out),
    .pink_out   (pink_out),
    .random_out (random_out)
  );

  assign out_tdata = OUT_W'({random_out, pink_out, white_out});

endmodule

/* src/pnrh_checker.sv */
`timescale 1ns / 1ps

module pnrh_checker #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int OUT_W = ((3 * SAMPLE_WIDTH + 6 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // nothing comes out right after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // queue starts empty
  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // a full queue only happens behind a stalled result
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tvalid && out_tready))
    else $error("queue full without a stalled result");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

endmodule

bind pink_noise_and_random_hold_core pnrh_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pnrh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
